FILE: rtl/clock_victim_selector_assert.svh
// assertion macros shared by the clock victim selector
`ifndef CLOCK_VICTIM_SELECTOR_ASSERT_SVH
`define CLOCK_VICTIM_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cvs_pkg.sv
`default_nettype none
package cvs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SEEN_W     = CNT_W + 1;

  // transaction kinds
  localparam logic [1:0] K_VICTIM = 2'd0;
  localparam logic [1:0] K_REF    = 2'd1;
  localparam logic [1:0] K_SET    = 2'd2;
  localparam logic [1:0] K_APPEND = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_VICTIM = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic occ;
    logic pin;
    logic acc;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [1:0]       status;
  } res_t;

  // next frame after pos, wrapping past the last present frame
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] pos,
                                               input logic [CNT_W-1:0] fp);
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, pos} + CNT_W'(1);
    return (nxt >= fp) ? '0 : nxt[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cvs_frame_mem.sv
`default_nettype none
module cvs_frame_mem
  import cvs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);

  entry_t           mem [MAX_FRAMES];
  entry_t           rdata_q;
  entry_t           fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q    <= mem[req_i.raddr];
    fwd_data_q <= req_i.wdata;
  end

  // a read that collides with a write in the same cycle sees the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule
`default_nettype wire

FILE: rtl/cvs_ctrl.sv
`default_nettype none
module cvs_ctrl
  import cvs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       kind_i,
  input  wire logic [IDX_W-1:0] frame_index_i,
  input  wire logic             occupied_i,
  input  wire logic             pinned_i,
  output logic                  in_stall_o,
  input  wire logic             out_free_i,
  output res_t                  res_o,
  output mem_req_t              mem_req_o,
  input  wire entry_t           mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REF  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  fp_q, fp_d;
  logic [IDX_W-1:0]  hand_q, hand_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [IDX_W-1:0]  start;
  logic              in_range;

  assign start    = ({1'b0, hand_q} >= fp_q) ? '0 : hand_q;
  assign in_range = ({1'b0, frame_index_i} < fp_q);

  always_comb begin
    state_d   = state_q;
    fp_d      = fp_q;
    hand_d    = hand_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    seen_d    = seen_q;
    res_idx_d = res_idx_q;
    res_st_d  = res_st_q;
    mem_req_o = '{we: 1'b0, waddr: cur_q, wdata: '0, raddr: pos_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_idx_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_RESP;
          case (kind_i)
            K_VICTIM: begin
              if (fp_q == '0) begin
                res_st_d = ST_NO_VICTIM;
              end else begin
                hand_d          = start;
                mem_req_o.raddr = start;
                cur_d           = start;
                pos_d           = advance(start, fp_q);
                seen_d          = '0;
                state_d         = S_SCAN;
              end
            end
            K_REF: begin
              if (!in_range) begin
                res_st_d = ST_RANGE;
              end else begin
                mem_req_o.raddr = frame_index_i;
                cur_d           = frame_index_i;
                state_d         = S_REF;
              end
            end
            K_SET: begin
              if (!in_range) begin
                res_st_d = ST_RANGE;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = frame_index_i;
                mem_req_o.wdata = '{occ: occupied_i, pin: pinned_i, acc: 1'b0};
              end
            end
            default: begin
              if (fp_q == CNT_W'(MAX_FRAMES)) begin
                res_st_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = fp_q[IDX_W-1:0];
                mem_req_o.wdata = '0;
                fp_d            = fp_q + CNT_W'(1);
                res_idx_d       = fp_q[IDX_W-1:0];
              end
            end
          endcase
        end
      end
      S_REF: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cur_q;
        mem_req_o.wdata = '{occ: mem_rdata_i.occ, pin: mem_rdata_i.pin, acc: 1'b1};
        state_d         = S_RESP;
      end
      S_SCAN: begin
        seen_d = seen_q + SEEN_W'(1);
        if (mem_rdata_i.occ && !mem_rdata_i.pin && !mem_rdata_i.acc) begin
          // victim found: pin it and move the hand past it
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_q;
          mem_req_o.wdata = '{occ: 1'b1, pin: 1'b1, acc: 1'b0};
          hand_d          = pos_q;
          res_idx_d       = cur_q;
          res_st_d        = ST_OK;
          state_d         = S_RESP;
        end else begin
          if (mem_rdata_i.occ && !mem_rdata_i.pin) begin
            // second chance: clear accessed and pass by
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = cur_q;
            mem_req_o.wdata = '{occ: 1'b1, pin: 1'b0, acc: 1'b0};
          end
          if (seen_d == {fp_q, 1'b0}) begin
            res_idx_d = '0;
            res_st_d  = ST_NO_VICTIM;
            state_d   = S_RESP;
          end else begin
            mem_req_o.raddr = pos_q;
            cur_d           = pos_q;
            pos_d           = advance(pos_q, fp_q);
          end
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fp_q    <= '0;
      hand_q  <= '0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
      hand_q  <= hand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    pos_q     <= pos_d;
    seen_q    <= seen_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_o      = '{valid: (state_q == S_RESP), idx: res_idx_q, status: res_st_q};

endmodule
`default_nettype wire

FILE: rtl/clock_victim_selector.sv
// sequence: append, set and out-of-range transactions go from idle straight to the result,
//   a reference reads the frame and writes it back, a victim request visits at most 2 * frames present frames
// throughput: one transaction at a time; the scan visits one frame per cycle,
//   bounded by the single read port of the frame memory
// reset: asynchronous active low; clears the hand, the frame count and the output
//   valid; frame bits need no clearing, every frame is written when appended
`default_nettype none
module clock_victim_selector
  import cvs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       kind_i,
  input  wire logic [IDX_W-1:0] frame_index_i,
  input  wire logic             occupied_i,
  input  wire logic             pinned_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IDX_W-1:0]      victim_index_o,
  output logic [1:0]            status_o
);

  mem_req_t         mem_req;
  entry_t           mem_rdata;
  res_t             res;
  logic             out_free;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q;
  logic [1:0]       out_st_q;

  // sequencer: decodes the transaction, runs the clock scan, builds the result
  cvs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .frame_index_i (frame_index_i),
    .occupied_i    (occupied_i),
    .pinned_i      (pinned_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // frame table: occupied, pinned, accessed per frame, registered read
  cvs_frame_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register decouples the result from the next transaction
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload only loads when a new result is taken into the register
  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      out_idx_q <= res.idx;
      out_st_q  <= res.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_index_o = out_idx_q;
  assign status_o       = out_st_q;

  `include "clock_victim_selector_assert.svh"

  // a failed transaction never reports a frame
  `CVS_ASSERT_NOW(a_fail_idx_zero, out_valid_o && (status_o != ST_OK), victim_index_o == '0, "nonzero index on failed transaction")
  // an accepted transaction keeps the input busy in the next cycle
  `CVS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not busy after accept")
  // a new result only appears while a transaction was in work
  `CVS_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result without transaction")

endmodule
`default_nettype wire
